// File: hdl/ple_pkg.sv
package ple_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int OP_W  = 3;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;

	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_CLEAR  = 3'd0;
	localparam op_t OP_INSERT = 3'd1;
	localparam op_t OP_UPDATE = 3'd2;
	localparam op_t OP_DELETE = 3'd3;
	localparam op_t OP_PRINT  = 3'd4;

	typedef logic [ST_W-1:0] status_t;
	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_BADPOS = 2'd1;
	localparam status_t ST_FULL   = 2'd2;
	localparam status_t ST_EMPTY  = 2'd3;

endpackage

// File: hdl/ple_ram.sv
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/positional_list_editor_core.sv
// Positional list editor: an ordered list of signed 32-bit entries kept in a
// single-port-write, single-port-read RAM, plus an entry count.
// Request channel (in_valid/in_ready): operation, position, value.
//   clear, insert, update, delete, print; one request is taken at a time,
//   in_ready is high only while the block is idle.
// Result channel (out_valid/out_ready): item_value, item_position, status,
//   last. Every request gives one result, print gives one per entry, and
//   last marks the final result of a request.
// Clear, update, unused codes, empty print and rejected requests go straight
//   to the result state. Insert (position 0 read as 1) and delete shift the
//   later entries, the RAM moving one entry per cycle (read, then write
//   back). Print gives one entry per cycle while the receiver keeps up,
//   limited by the single RAM read port.
// The next request is taken the cycle after the final result is loaded, so
//   requests never overlap.
// A stalled receiver holds the output register; shifting continues, print
//   pauses its reads until the register frees up.
// Reset empties the list and idles the block; RAM contents are not cleared.
module positional_list_editor_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ple_pkg::OP_W-1:0]          operation,
	input  logic [ple_pkg::POS_W-1:0]         position,
	input  logic signed [ple_pkg::VAL_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ple_pkg::VAL_W-1:0]  item_value,
	output logic [ple_pkg::POS_W-1:0]         item_position,
	output logic [ple_pkg::ST_W-1:0]          status,
	output logic                              last
);

	localparam int AW = ple_pkg::ADDR_W;
	localparam int CW = ple_pkg::CNT_W;
	localparam int MW = ple_pkg::CMP_W;

	typedef enum logic [2:0] {S_IDLE, S_UP, S_DOWN, S_PRINT, S_RESP} state_t;

	state_t                       state_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                idx_q;
	logic [CW-1:0]                tgt_q;
	logic [ple_pkg::VAL_W-1:0]    val_q;
	ple_pkg::status_t             status_q;
	logic                         wpend_s1;
	logic [AW-1:0]                waddr_s1;
	logic                         rvalid_s1;
	logic [CW-1:0]                ridx_s1;
	logic                         out_valid_q;
	logic [ple_pkg::VAL_W-1:0]    item_value_q;
	logic [ple_pkg::POS_W-1:0]    item_position_q;
	ple_pkg::status_t             status_out_q;
	logic                         last_q;

	logic                         accept;
	logic [MW-1:0]                pos_c;
	logic [MW-1:0]                pos_eff;
	logic [MW-1:0]                pos_m1;
	logic [MW-1:0]                cnt_c;
	logic                         full;
	logic                         ins_bad;
	logic                         edit_bad;
	logic                         can_load;
	logic                         up_move;
	logic                         down_move;
	logic                         pr_issue;
	logic                         pr_load;
	logic [CW-1:0]                raddr_c;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [ple_pkg::VAL_W-1:0]    ram_wdata;
	logic                         ram_re;
	logic [ple_pkg::VAL_W-1:0]    ram_rdata;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign pos_c    = MW'(position);
	assign pos_eff  = (position == '0) ? MW'(1) : pos_c;
	assign pos_m1   = pos_c - MW'(1);
	assign cnt_c    = MW'(count_q);
	assign full     = cnt_c >= MW'(ple_pkg::CAPACITY);
	assign ins_bad  = pos_eff > (cnt_c + MW'(1));
	assign edit_bad = (pos_c == '0) || (pos_c > cnt_c);

	assign can_load  = !out_valid_q || out_ready;
	assign up_move   = (state_q == S_UP) && (idx_q != tgt_q);
	assign down_move = (state_q == S_DOWN)
		&& (({1'b0, idx_q} + (CW+1)'(1)) < {1'b0, count_q});
	assign pr_issue  = (state_q == S_PRINT) && (idx_q != count_q)
		&& (!rvalid_s1 || can_load);
	assign pr_load   = (state_q == S_PRINT) && rvalid_s1 && can_load;

	always_comb begin
		case (state_q)
			S_UP:    raddr_c = idx_q - CW'(1);
			S_DOWN:  raddr_c = idx_q + CW'(1);
			default: raddr_c = idx_q;
		endcase
	end

	assign ram_re = up_move || down_move || pr_issue;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_m1[AW-1:0];
		ram_wdata = value;
		if (wpend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = waddr_s1;
			ram_wdata = ram_rdata;
		end else if (state_q == S_UP && !up_move) begin
			ram_we    = 1'b1;
			ram_waddr = tgt_q[AW-1:0];
			ram_wdata = val_q;
		end else if (accept && operation == ple_pkg::OP_UPDATE && !edit_bad) begin
			ram_we    = 1'b1;
		end
	end

	ple_ram #(
		.WIDTH(ple_pkg::VAL_W),
		.DEPTH(ple_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (raddr_c[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			idx_q           <= '0;
			tgt_q           <= '0;
			val_q           <= '0;
			status_q        <= ple_pkg::ST_OK;
			wpend_s1        <= 1'b0;
			waddr_s1        <= '0;
			rvalid_s1       <= 1'b0;
			ridx_s1         <= '0;
			out_valid_q     <= 1'b0;
			item_value_q    <= '0;
			item_position_q <= '0;
			status_out_q    <= ple_pkg::ST_OK;
			last_q          <= 1'b0;
		end else begin
			wpend_s1 <= up_move || down_move;
			waddr_s1 <= idx_q[AW-1:0];
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q    <= value;
						status_q <= ple_pkg::ST_OK;
						state_q  <= S_RESP;
						case (operation)
							ple_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							ple_pkg::OP_INSERT: begin
								if (full) begin
									status_q <= ple_pkg::ST_FULL;
								end else if (ins_bad) begin
									status_q <= ple_pkg::ST_BADPOS;
								end else begin
									idx_q   <= count_q;
									tgt_q   <= CW'(pos_eff - MW'(1));
									state_q <= S_UP;
								end
							end
							ple_pkg::OP_UPDATE: begin
								if (edit_bad) begin
									status_q <= ple_pkg::ST_BADPOS;
								end
							end
							ple_pkg::OP_DELETE: begin
								if (edit_bad) begin
									status_q <= ple_pkg::ST_BADPOS;
								end else begin
									idx_q   <= CW'(pos_m1);
									state_q <= S_DOWN;
								end
							end
							ple_pkg::OP_PRINT: begin
								if (count_q == '0) begin
									status_q <= ple_pkg::ST_EMPTY;
								end else begin
									idx_q   <= '0;
									state_q <= S_PRINT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_UP: begin
					if (up_move) begin
						idx_q <= idx_q - CW'(1);
					end else if (!wpend_s1) begin
						count_q <= count_q + CW'(1);
						state_q <= S_RESP;
					end
				end
				S_DOWN: begin
					if (down_move) begin
						idx_q <= idx_q + CW'(1);
					end else if (!wpend_s1) begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				S_PRINT: begin
					if (pr_issue) begin
						rvalid_s1 <= 1'b1;
						ridx_s1   <= idx_q;
						idx_q     <= idx_q + CW'(1);
					end else if (pr_load) begin
						rvalid_s1 <= 1'b0;
					end
					if (pr_load) begin
						out_valid_q     <= 1'b1;
						item_value_q    <= ram_rdata;
						item_position_q <= ple_pkg::POS_W'({1'b0, ridx_s1} + (CW+1)'(1));
						status_out_q    <= ple_pkg::ST_OK;
						last_q          <= ({1'b0, ridx_s1} + (CW+1)'(1)) == {1'b0, count_q};
					end
					if (idx_q == count_q && (!rvalid_s1 || pr_load)) begin
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (can_load) begin
						out_valid_q     <= 1'b1;
						item_value_q    <= '0;
						item_position_q <= '0;
						status_out_q    <= status_q;
						last_q          <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign item_value    = item_value_q;
	assign item_position = item_position_q;
	assign status        = status_out_q;
	assign last          = last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= (CW+1)'(ple_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != raddr_c[AW-1:0]))
		else $error("read and write to the same entry in one cycle");

	a_print_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PRINT) |-> (count_q != '0))
		else $error("print running on an empty list");

	a_rvalid_in_print: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 |-> (state_q == S_PRINT))
		else $error("read data pending outside print");

	a_shift_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_UP || state_q == S_DOWN) && !out_valid_q) |=> !out_valid_q)
		else $error("result issued during shift");

endmodule

// File: verif/tb_positional_list_editor_core.sv
module tb_positional_list_editor_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam ple_pkg::op_t OP_SPARE5 = 3'd5;
	localparam ple_pkg::op_t OP_SPARE6 = 3'd6;
	localparam ple_pkg::op_t OP_SPARE7 = 3'd7;

	localparam int NUM_DIRECTED  = 25;
	localparam int NUM_RANDOM    = 10;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 80;
	localparam int REPORT_LIMIT  = 10;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	typedef struct packed {
		logic signed [ple_pkg::VAL_W-1:0] item_value;
		logic [ple_pkg::POS_W-1:0]        item_position;
		ple_pkg::status_t                 status;
		logic                             last;
	} listing_t;

	typedef struct packed {
		ple_pkg::op_t                     op;
		logic [ple_pkg::POS_W-1:0]        pos;
		logic signed [ple_pkg::VAL_W-1:0] val;
		logic                             typed;
		ple_pkg::status_t                 st;
	} request_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ple_pkg::OP_W-1:0] operation = '0;
	logic [ple_pkg::POS_W-1:0] position = '0;
	logic signed [ple_pkg::VAL_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [ple_pkg::VAL_W-1:0] item_value;
	logic [ple_pkg::POS_W-1:0] item_position;
	logic [ple_pkg::ST_W-1:0] status;
	logic last;

	logic signed [ple_pkg::VAL_W-1:0] list_mem [ple_pkg::CAPACITY];
	int list_len = 0;
	listing_t expected_listing [$];

	request_row_t directed_rows [NUM_DIRECTED];

	int burst_left = 0;
	int mismatches = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int longest_list = 0;
	int full_rejects = 0;
	int prints_issued = 0;
	int idle_cycles = 0;

	rx_mode_t rx_mode = RX_OPEN;
	int rx_left = 0;
	int rx_tick = 0;

	positional_list_editor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_value(item_value),
		.item_position(item_position),
		.status(status),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void predict_request(ple_pkg::op_t op,
			logic [ple_pkg::POS_W-1:0] pos, logic signed [ple_pkg::VAL_W-1:0] val);
		listing_t r;
		int p;
		int i;
		r = '{item_value: '0, item_position: '0, status: ple_pkg::ST_OK, last: 1'b1};
		p = pos;
		case (op)
			ple_pkg::OP_CLEAR: list_len = 0;
			ple_pkg::OP_INSERT: begin
				if (p == 0)
					p = 1;
				if (list_len >= ple_pkg::CAPACITY) begin
					r.status = ple_pkg::ST_FULL;
					full_rejects++;
				end else if (p > list_len + 1) begin
					r.status = ple_pkg::ST_BADPOS;
				end else begin
					for (i = list_len; i > p - 1; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p-1] = val;
					list_len++;
				end
			end
			ple_pkg::OP_UPDATE: begin
				if (p < 1 || p > list_len)
					r.status = ple_pkg::ST_BADPOS;
				else
					list_mem[p-1] = val;
			end
			ple_pkg::OP_DELETE: begin
				if (p < 1 || p > list_len) begin
					r.status = ple_pkg::ST_BADPOS;
				end else begin
					for (i = p - 1; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			ple_pkg::OP_PRINT: begin
				prints_issued++;
				if (list_len == 0) begin
					r.status = ple_pkg::ST_EMPTY;
				end else begin
					for (i = 0; i < list_len; i++) begin
						r.item_value = list_mem[i];
						r.item_position = ple_pkg::POS_W'(i + 1);
						r.status = ple_pkg::ST_OK;
						r.last = (i + 1 == list_len);
						expected_listing.push_back(r);
					end
					return;
				end
			end
			default: ;
		endcase
		if (list_len > longest_list)
			longest_list = list_len;
		expected_listing.push_back(r);
	endfunction

	task automatic send_request(input ple_pkg::op_t op, input logic [ple_pkg::POS_W-1:0] pos,
			input logic signed [ple_pkg::VAL_W-1:0] val, input logic typed = 1'b0,
			input ple_pkg::status_t typed_st = ple_pkg::ST_OK);
		int gap;
		int base;
		listing_t r;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		base = expected_listing.size();
		predict_request(op, pos, val);
		if (typed) begin
			while (expected_listing.size() > base)
				void'(expected_listing.pop_back());
			r = '{item_value: '0, item_position: '0, status: typed_st, last: 1'b1};
			expected_listing.push_back(r);
		end
		in_valid <= 1'b1;
		operation <= op;
		position <= pos;
		value <= val;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		requests_sent++;
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_listing.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [ple_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(20, 150);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
			default: out_ready <= ((rx_tick % 9) < 5);
		endcase
	end

	always @(posedge clk) begin
		listing_t exp_r;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		if (out_valid && out_ready) begin
			results_seen++;
			if (expected_listing.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: value %0d pos %0d status %0d last %0b",
						item_value, item_position, status, last);
			end else begin
				exp_r = expected_listing.pop_front();
				if (exp_r.item_value !== item_value || exp_r.item_position !== item_position
						|| exp_r.status !== status || exp_r.last !== last) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("mismatch at result %0d: expected value %0d pos %0d status %0d last %0b",
							results_seen, exp_r.item_value, exp_r.item_position,
							exp_r.status, exp_r.last);
						$display("  got value %0d pos %0d status %0d last %0b",
							item_value, item_position, status, last);
					end
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		int k;
		int kind;
		directed_rows = '{
			'{ple_pkg::OP_PRINT,  7'd0,   32'sd0,        1'b1, ple_pkg::ST_EMPTY},
			'{ple_pkg::OP_DELETE, 7'd1,   32'sd0,        1'b1, ple_pkg::ST_BADPOS},
			'{ple_pkg::OP_UPDATE, 7'd0,   32'sd5,        1'b1, ple_pkg::ST_BADPOS},
			'{ple_pkg::OP_INSERT, 7'd0,   32'sh7fffffff, 1'b0, ple_pkg::ST_OK},
			'{ple_pkg::OP_INSERT, 7'd3,   32'sd9,        1'b1, ple_pkg::ST_BADPOS},
			'{ple_pkg::OP_INSERT, 7'd2,   32'sh80000000, 1'b0, ple_pkg::ST_OK},
			'{ple_pkg::OP_INSERT, 7'd1,   -32'sd1,       1'b0, ple_pkg::ST_OK},
			'{ple_pkg::OP_INSERT, 7'd2,   32'sd0,        1'b0, ple_pkg::ST_OK},
			'{ple_pkg::OP_PRINT,  7'd0,   32'sd0,        1'b0, ple_pkg::ST_OK},
			'{ple_pkg::OP_UPDATE, 7'd4,   32'sh5a5a5a5a, 1'b0, ple_pkg::ST_OK},
			'{ple_pkg::OP_UPDATE, 7'd5,   32'sd1,        1'b1, ple_pkg::ST_BADPOS},
			'{ple_pkg::OP_DELETE, 7'd0,   32'sd0,        1'b1, ple_pkg::ST_BADPOS},
			'{ple_pkg::OP_DELETE, 7'd4,   32'sd0,        1'b0, ple_pkg::ST_OK},
			'{ple_pkg::OP_DELETE, 7'd1,   32'sd0,        1'b0, ple_pkg::ST_OK},
			'{ple_pkg::OP_PRINT,  7'd127, -32'sd1,       1'b0, ple_pkg::ST_OK},
			'{OP_SPARE5,          7'd127, 32'sh7fffffff, 1'b0, ple_pkg::ST_OK},
			'{OP_SPARE6,          7'd1,   32'sd3,        1'b0, ple_pkg::ST_OK},
			'{OP_SPARE7,          7'd127, -32'sd1,       1'b0, ple_pkg::ST_OK},
			'{ple_pkg::OP_INSERT, 7'd127, 32'sd1,        1'b1, ple_pkg::ST_BADPOS},
			'{ple_pkg::OP_UPDATE, 7'd127, 32'sd2,        1'b1, ple_pkg::ST_BADPOS},
			'{ple_pkg::OP_CLEAR,  7'd127, -32'sd1,       1'b1, ple_pkg::ST_OK},
			'{ple_pkg::OP_PRINT,  7'd0,   32'sd0,        1'b1, ple_pkg::ST_EMPTY},
			'{ple_pkg::OP_INSERT, 7'd0,   32'sh12345678, 1'b0, ple_pkg::ST_OK},
			'{ple_pkg::OP_DELETE, 7'd1,   32'sd0,        1'b0, ple_pkg::ST_OK},
			'{ple_pkg::OP_PRINT,  7'd0,   32'sd0,        1'b1, ple_pkg::ST_EMPTY}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < NUM_DIRECTED; k++)
			send_request(directed_rows[k].op, directed_rows[k].pos, directed_rows[k].val,
				directed_rows[k].typed, directed_rows[k].st);
		hold_until_drained();

		// fill to capacity, then hit the full-list and boundary cases
		while (list_len < ple_pkg::CAPACITY)
			send_request(ple_pkg::OP_INSERT,
				ple_pkg::POS_W'($urandom_range(0, list_len + 1)), pick_value());
		send_request(ple_pkg::OP_INSERT,
			ple_pkg::POS_W'($urandom_range(0, ple_pkg::CAPACITY)), pick_value());
		send_request(ple_pkg::OP_INSERT, 7'd127, pick_value());
		send_request(ple_pkg::OP_PRINT, ple_pkg::POS_W'($urandom), pick_value());
		send_request(ple_pkg::OP_UPDATE, ple_pkg::POS_W'(ple_pkg::CAPACITY), pick_value());
		send_request(ple_pkg::OP_UPDATE, ple_pkg::POS_W'(ple_pkg::CAPACITY + 1), pick_value());
		send_request(ple_pkg::OP_DELETE, ple_pkg::POS_W'(ple_pkg::CAPACITY), pick_value());
		send_request(ple_pkg::OP_INSERT, ple_pkg::POS_W'(ple_pkg::CAPACITY), pick_value());
		send_request(ple_pkg::OP_DELETE, 7'd1, pick_value());
		send_request(ple_pkg::OP_DELETE, ple_pkg::POS_W'(ple_pkg::CAPACITY + 1), pick_value());
		hold_until_drained();
		send_request(ple_pkg::OP_CLEAR, ple_pkg::POS_W'($urandom), pick_value());

		for (k = 0; k < NUM_RANDOM; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 30)
				send_request(ple_pkg::OP_INSERT,
					ple_pkg::POS_W'($urandom_range(0, list_len + 1)), pick_value());
			else if (kind < 44)
				send_request(ple_pkg::OP_UPDATE,
					ple_pkg::POS_W'($urandom_range(1, list_len + 1)), pick_value());
			else if (kind < 68)
				send_request(ple_pkg::OP_DELETE,
					ple_pkg::POS_W'($urandom_range(1, list_len + 1)), pick_value());
			else if (kind < 77)
				send_request(ple_pkg::OP_PRINT, ple_pkg::POS_W'($urandom), pick_value());
			else if (kind < 80)
				send_request(ple_pkg::OP_CLEAR, ple_pkg::POS_W'($urandom), pick_value());
			else
				send_request(ple_pkg::op_t'($urandom_range(0, 7)),
					ple_pkg::POS_W'($urandom), pick_value());
		end

		in_valid <= 1'b0;
		while (expected_listing.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_listing.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", expected_listing.size());
		end

		$display("sent %0d requests (%0d prints, %0d full-list rejects), checked %0d results",
			requests_sent, prints_issued, full_rejects, results_seen);
		$display("longest list %0d entries, %0d mismatches", longest_list, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
hdl/ple_pkg.sv
hdl/ple_ram.sv
hdl/positional_list_editor_core.sv
verif/tb_positional_list_editor_core.sv
